/* rtl/core/lin_frame_response_receiver_assert.svh */
// assertion macros used by the receiver top level
`ifndef LIN_FRAME_RESPONSE_RECEIVER_ASSERT_SVH
`define LIN_FRAME_RESPONSE_RECEIVER_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define LFRR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define LFRR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lfrr_pkg.sv */
package lfrr_pkg;

	// fixed field and datapath widths
	localparam int BAUD_W = 15;
	localparam int SUM_W  = 12;
	localparam int NUM_W  = 17;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	// protocol constants
	localparam logic [7:0]        SYNC_BYTE   = 8'h55;
	localparam logic [BAUD_W-1:0] BAUD_RESET  = 15'd19200;
	localparam logic [NUM_W-1:0]  HDR_NUMER   = 17'd22000;
	localparam int                DATA_NUMER  = 10000;
	localparam logic [2:0]        HDR_BASE    = 3'd3;
	localparam logic [2:0]        DATA_BASE   = 3'd5;

	// input command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_code_t;

	// result status codes
	typedef enum logic [1:0] {
		RS_DATA    = 2'd0,
		RS_GOOD    = 2'd1,
		RS_BAD     = 2'd2,
		RS_TIMEOUT = 2'd3
	} rstat_t;

	// controller states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SYNC,
		CS_ID,
		CS_DATA,
		CS_DIV_HDR,
		CS_DIV_DATA
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic   load_frame;
		logic   div_go;
		logic   div_data;
		logic   clr_elapsed;
		logic   inc_elapsed;
		logic   take_data;
		logic   emit;
		rstat_t emit_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic timeout;
		logic more_data;
		logic sum_match;
		logic sync_seen;
		logic out_blocked;
	} dp_stat_t;

	// lin 2.x protected identifier
	function automatic logic [7:0] protect_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

endpackage

/* rtl/core/lfrr_ctrl.sv */
module lfrr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       command,
	input  lfrr_pkg::dp_stat_t stat,
	output lfrr_pkg::dp_cmd_t  cmd
);
	import lfrr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        busy;
	logic        accept;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		busy     = (state_q == CS_DIV_HDR) || (state_q == CS_DIV_DATA);
		in_stall = busy || stat.out_blocked;
		accept   = in_valid && !in_stall;
		cmd.emit_status = RS_DATA;

		priority if (busy) begin
			if (stat.div_done) begin
				state_d = (state_q == CS_DIV_HDR) ? CS_SYNC : CS_DATA;
			end
		end else if (accept && command == CMD_START) begin
			// start always rearms, even mid-frame
			cmd.load_frame  = 1'b1;
			cmd.clr_elapsed = 1'b1;
			cmd.div_go      = 1'b1;
			cmd.div_data    = 1'b0;
			state_d         = CS_DIV_HDR;
		end else if (accept && state_q != CS_IDLE) begin
			unique case (command)
				CMD_TICK: begin
					if (stat.timeout) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = RS_TIMEOUT;
						state_d         = CS_IDLE;
					end else begin
						cmd.inc_elapsed = 1'b1;
					end
				end
				CMD_BYTE: begin
					unique case (state_q)
						CS_SYNC: begin
							if (stat.sync_seen) begin
								state_d = CS_ID;
							end
						end
						CS_ID: begin
							cmd.clr_elapsed = 1'b1;
							cmd.div_go      = 1'b1;
							cmd.div_data    = 1'b1;
							state_d         = CS_DIV_DATA;
						end
						CS_DATA: begin
							cmd.emit = 1'b1;
							if (stat.more_data) begin
								cmd.take_data   = 1'b1;
								cmd.emit_status = RS_DATA;
							end else begin
								cmd.emit_status = stat.sum_match ? RS_GOOD : RS_BAD;
								state_d         = CS_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end else begin
			// nothing accepted, hold state
		end
	end

endmodule

/* rtl/core/lfrr_dpath.sv */
module lfrr_dpath #(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lfrr_pkg::BAUD_W-1:0] cfg_wr_data,
	input  logic [5:0]                  frame_id,
	input  logic [3:0]                  data_length,
	input  logic [7:0]                  rx_byte,
	input  lfrr_pkg::dp_cmd_t           cmd,
	output lfrr_pkg::dp_stat_t          stat,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [1:0]                  status,
	output logic [2:0]                  byte_index,
	output logic [7:0]                  data_byte
);
	import lfrr_pkg::*;

	localparam int LEN_W = $clog2(MAX_DATA_BYTES + 1);

	logic [BAUD_W-1:0] baud_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        elapsed_q;
	logic [7:0]        deadline_q;

	logic [LEN_W-1:0]  len_clamped;
	logic [8:0]        fold1;
	logic [7:0]        fold2;
	logic [7:0]        expect_sum;

	logic              div_run_q;
	logic              div_data_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [BAUD_W:0]   rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [BAUD_W:0]   trial;
	logic [BAUD_W+1:0] diff;
	logic              div_last;
	logic [NUM_W:0]    dl_sum;
	logic [7:0]        dl_sat;

	logic              out_valid_q;
	rstat_t            status_q;
	logic [2:0]        idx_q;
	logic [7:0]        data_q;

	// baud rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q <= BAUD_RESET;
		end else if (cfg_wr_en) begin
			baud_q <= cfg_wr_data;
		end
	end

	// length clamp and checksum fold with end-around carry
	always_comb begin
		len_clamped = (data_length > 4'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES)
		                                                  : LEN_W'(data_length);
		fold1       = {1'b0, sum_q[7:0]} + 9'(sum_q[SUM_W-1:8]);
		fold2       = fold1[7:0] + {7'd0, fold1[8]};
		expect_sum  = ~fold2;
	end

	// frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			elapsed_q <= '0;
		end else begin
			if (cmd.load_frame) begin
				len_q   <= len_clamped;
				count_q <= '0;
				sum_q   <= SUM_W'(protect_id(frame_id));
			end else if (cmd.take_data) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(rx_byte);
			end
			if (cmd.clr_elapsed) begin
				elapsed_q <= '0;
			end else if (cmd.inc_elapsed) begin
				elapsed_q <= elapsed_q + 8'd1;
			end
		end
	end

	// restoring divider step and saturated deadline
	always_comb begin
		trial    = {rem_q[BAUD_W-1:0], quo_q[NUM_W-1]};
		diff     = {1'b0, trial} - {2'b00, baud_q};
		div_last = div_run_q && (div_cnt_q == CNT_W'(NUM_W));
		dl_sum   = {1'b0, quo_q} + (NUM_W + 1)'(div_data_q ? DATA_BASE : HDR_BASE);
		dl_sat   = (dl_sum > (NUM_W + 1)'(255)) ? 8'hFF : dl_sum[7:0];
	end

	// bit-serial deadline divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q  <= 1'b0;
			div_data_q <= 1'b0;
			div_cnt_q  <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			deadline_q <= '0;
		end else if (cmd.div_go) begin
			div_run_q  <= 1'b1;
			div_data_q <= cmd.div_data;
			div_cnt_q  <= '0;
			rem_q      <= '0;
			quo_q      <= cmd.div_data ? NUM_W'(len_q) * NUM_W'(DATA_NUMER) : HDR_NUMER;
		end else if (div_last) begin
			div_run_q  <= 1'b0;
			deadline_q <= dl_sat;
		end else if (div_run_q) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (!diff[BAUD_W+1]) begin
				rem_q <= diff[BAUD_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			idx_q    <= cmd.take_data ? 3'(count_q) : 3'd0;
			data_q   <= cmd.take_data ? rx_byte : 8'd0;
		end
	end

	// status back to the controller
	always_comb begin
		stat.div_done    = div_last;
		stat.timeout     = elapsed_q >= deadline_q;
		stat.more_data   = count_q < len_q;
		stat.sum_match   = expect_sum == rx_byte;
		stat.sync_seen   = rx_byte == SYNC_BYTE;
		stat.out_blocked = out_valid_q && out_stall;
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign byte_index = idx_q;
	assign data_byte  = data_q;

endmodule

/* rtl/core/lin_frame_response_receiver.sv */
// LIN response receiver on the master side with enhanced checksum. A start item
// (frame_id, data_length) arms one frame; received bytes are skipped until the
// 0x55 sync, the next byte is the echoed identifier, then each data byte comes
// out with its index, and the byte after the last one is checked against the
// inverted end-around-carry sum of protected identifier and data. One-ms tick
// items time out the header and the data phase; each deadline comes from
// baud_rate through a bit-serial divider. After a start item or the identifier
// byte, input stays stalled while the divider produces one quotient bit per
// cycle over 17 bits, until the deadline is written. A finished result waits
// in the output register while the next item is taken, unless that register is
// still held by out_stall. baud_rate is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while idle, the block does not enforce.
module lin_frame_response_receiver #(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lfrr_pkg::BAUD_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [5:0]                  frame_id,
	input  logic [3:0]                  data_length,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [2:0]                  byte_index,
	output logic [7:0]                  data_byte
);
	import lfrr_pkg::*;

	`include "lin_frame_response_receiver_assert.svh"

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// frame sequencer
	lfrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// counters, checksum, divider and result register
	lfrr_dpath #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame_id    (frame_id),
		.data_length (data_length),
		.rx_byte     (rx_byte),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.byte_index  (byte_index),
		.data_byte   (data_byte)
	);

	// a start item always engages the divider on the next cycle
	`LFRR_ASSERT_NXT(a_start_stalls, in_valid && !in_stall && command == CMD_START, in_stall, "start item did not stall input for the deadline division")

	// a new result only follows an accepted item
	`LFRR_ASSERT_IMP(a_result_from_item, $rose(out_valid), $past(in_valid && !in_stall), "result appeared without an accepted item")

	// the divider never finishes while the datapath is being commanded
	`LFRR_ASSERT_IMP(a_done_while_stalled, dp_stat.div_done, in_stall && !dp_cmd.emit, "divider finished outside a stalled division")

endmodule

/* tb/lin_response_checker.sv */
module lin_response_checker #(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lfrr_pkg::BAUD_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [5:0]                  frame_id,
	input  logic [3:0]                  data_length,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  status,
	input  logic [2:0]                  byte_index,
	input  logic [7:0]                  data_byte,
	output int                          error_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lfrr_pkg::*;

	// protocol numbers as the frame format defines them
	localparam logic [7:0]  SYNC_PATTERN       = 8'h55;
	localparam logic [14:0] RESET_BPS          = 15'd19200;
	localparam int          HEADER_SLACK_MS    = 3;
	localparam int          HEADER_WORK        = 2 * 11 * 1000;
	localparam int          DATA_SLACK_MS      = 5;
	localparam int          DATA_WORK_PER_BYTE = 10 * 1000;
	localparam int          MS_CEILING         = 255;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_SYNC,
		RX_ID,
		RX_DATA
	} rx_phase_t;

	typedef struct packed {
		rstat_t     status;
		logic [2:0] index;
		logic [7:0] value;
	} lin_result_t;

	lin_result_t expected_results[$];
	lin_result_t want;

	// shadow of the receiver state
	logic [14:0] baud_bps;
	rx_phase_t   rx_phase;
	logic [3:0]  bytes_seen;
	logic [3:0]  bytes_wanted;
	logic [11:0] sum_acc;
	logic [7:0]  elapsed;
	logic [7:0]  deadline;

	// lin 2.x parity bits on top of the six-bit identifier
	function automatic logic [7:0] protected_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// slack plus work over baud rate, saturating, zero rate gives the ceiling
	function automatic logic [7:0] deadline_ms(input int slack, input int work);
		int d;
		if (baud_bps == 0)
			return 8'(MS_CEILING);
		d = slack + work / int'(baud_bps);
		return (d > MS_CEILING) ? 8'(MS_CEILING) : 8'(d);
	endfunction

	// end-around-carry fold to eight bits, then inverted
	function automatic logic [7:0] checksum_of(input logic [11:0] total);
		int folded;
		folded = (total == 0) ? 0 : ((int'(total) - 1) % 255) + 1;
		return ~folded[7:0];
	endfunction

	// advance the shadow state by one item and queue what it should produce
	task automatic predict_response(input logic [1:0] cmd, input logic [5:0] fid,
			input logic [3:0] len, input logic [7:0] rx);
		lin_result_t res;
		res = '{status: RS_DATA, index: 3'd0, value: 8'd0};
		if (cmd == CMD_START) begin
			bytes_wanted = (len > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES) : len;
			bytes_seen = 4'd0;
			sum_acc = {4'd0, protected_id(fid)};
			elapsed = 8'd0;
			deadline = deadline_ms(HEADER_SLACK_MS, HEADER_WORK);
			rx_phase = RX_SYNC;
			return;
		end
		if (rx_phase == RX_IDLE)
			return;
		case (cmd)
			CMD_TICK: begin
				if (elapsed >= deadline) begin
					rx_phase = RX_IDLE;
					res.status = RS_TIMEOUT;
					expected_results.push_back(res);
				end else begin
					elapsed = elapsed + 8'd1;
				end
			end
			CMD_BYTE: begin
				case (rx_phase)
					RX_SYNC: begin
						if (rx == SYNC_PATTERN)
							rx_phase = RX_ID;
					end
					RX_ID: begin
						elapsed = 8'd0;
						deadline = deadline_ms(DATA_SLACK_MS,
							int'(bytes_wanted) * DATA_WORK_PER_BYTE);
						rx_phase = RX_DATA;
					end
					default: begin
						if (bytes_seen < bytes_wanted) begin
							res.index = bytes_seen[2:0];
							res.value = rx;
							sum_acc = sum_acc + 12'(rx);
							bytes_seen = bytes_seen + 4'd1;
						end else begin
							res.status = (rx == checksum_of(sum_acc)) ? RS_GOOD : RS_BAD;
							rx_phase = RX_IDLE;
						end
						expected_results.push_back(res);
					end
				endcase
			end
			default: ;
		endcase
	endtask

	// compare delivered results, then track config writes and accepted items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_bps = RESET_BPS;
			rx_phase = RX_IDLE;
			bytes_seen = 4'd0;
			bytes_wanted = 4'd0;
			sum_acc = 12'd0;
			elapsed = 8'd0;
			deadline = 8'd0;
			expected_results.delete();
			error_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, %s%0d %s%0d %s%02h",
						$time, "actual status=", status, "index=", byte_index,
						"byte=", data_byte);
					error_count <= error_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.status !== status || want.index !== byte_index ||
							want.value !== data_byte) begin
						$display("%0t: mismatch: expected status=%0d index=%0d byte=%02h, %s%0d %s%0d %s%02h",
							$time, want.status, want.index, want.value,
							"actual status=", status, "index=", byte_index,
							"byte=", data_byte);
						error_count <= error_count + 1;
					end
				end
			end
			if (cfg_wr_en)
				baud_bps = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_response(command, frame_id, data_length, rx_byte);
			pending <= expected_results.size();
		end
	end

endmodule

/* tb/tb_lin_frame_response_receiver.sv */
module tb_lin_frame_response_receiver;
	timeunit 1ns;
	timeprecision 1ps;
	import lfrr_pkg::*;

	localparam int         PERIOD       = 10;
	localparam logic [1:0] CMD_SPARE    = 2'd3;
	localparam int         QUIET_LIMIT  = 3000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         PHASE_ITEMS  = 40;
	localparam int         PHASE_COUNT  = 12;
	localparam int         CORNER_COUNT = 7;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [BAUD_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = '0;
	logic [5:0]        frame_id = '0;
	logic [3:0]        data_length = '0;
	logic [7:0]        rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [2:0]        byte_index;
	logic [7:0]        data_byte;

	int error_count;
	int pending;
	int quiet_cycles = 0;
	int sent_items = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// reset rate, both edges of the range, the widest value, zero and tiny rates
	logic [BAUD_W-1:0] corner_rates [CORNER_COUNT] =
		'{15'd19200, 15'd20000, 15'd1000, 15'h7FFF, 15'd0, 15'd1, 15'd50};

	always #(PERIOD / 2) clk = ~clk;

	lin_frame_response_receiver DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.frame_id    (frame_id),
		.data_length (data_length),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.byte_index  (byte_index),
		.data_byte   (data_byte)
	);

	lin_response_checker u_response_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.frame_id    (frame_id),
		.data_length (data_length),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.byte_index  (byte_index),
		.data_byte   (data_byte),
		.error_count (error_count),
		.pending     (pending)
	);

	// result side back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// count cycles in which no item moves on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_lin_frame_response_receiver: errors");
		$finish;
	end

	// present one item, with optional gaps, and hold it until taken
	task automatic send_item(input logic [1:0] cmd, input logic [5:0] fid,
			input logic [3:0] len, input logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		frame_id <= fid;
		data_length <= len;
		rx_byte <= rx;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic send_start(input logic [5:0] fid, input logic [3:0] len);
		send_item(CMD_START, fid, len, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] rx);
		send_item(CMD_BYTE, 6'($urandom), 4'($urandom), rx);
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 6'($urandom), 4'($urandom), 8'($urandom));
	endtask

	// checksum byte that makes a well-formed frame
	function automatic logic [7:0] frame_checksum(input logic [11:0] total);
		int folded;
		folded = (total == 0) ? 0 : ((int'(total) - 1) % 255) + 1;
		return ~folded[7:0];
	endfunction

	// between bytes: a rare tick, or a run of ticks to time out; rarely a stray item
	task automatic idle_ticks(input bit burst, input int max_burst);
		int n;
		n = burst ? $urandom_range(max_burst) : int'($urandom_range(9) == 0);
		repeat (n) send_tick();
		if ($urandom_range(24) == 0)
			send_item(2'($urandom), 6'($urandom), 4'($urandom), 8'($urandom));
	endtask

	// one response frame, mostly well formed, sometimes cut, late or corrupted
	task automatic send_frame(input int max_burst);
		logic [5:0]  fid;
		logic [3:0]  len;
		logic [11:0] total;
		logic [7:0]  value;
		int n;
		int kind;
		int cut;
		int burst_at;
		fid = 6'($urandom);
		len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
		n = (len > 8) ? 8 : int'(len);
		kind = $urandom_range(99);
		cut = (kind < 8) ? $urandom_range(n + 1) : -1;
		burst_at = (kind >= 8 && kind < 18) ? $urandom_range(n + 2) : -1;
		total = {4'd0, protect_id(fid)};
		send_start(fid, len);
		// line noise ahead of the sync byte
		for (int i = $urandom_range(2); i > 0; i--) begin
			value = 8'($urandom);
			send_byte((value == SYNC_BYTE) ? ~value : value);
		end
		idle_ticks(burst_at == 0, max_burst);
		if (cut == 0)
			return;
		send_byte(SYNC_BYTE);
		idle_ticks(burst_at == 1, max_burst);
		send_byte(8'($urandom));
		for (int i = 0; i < n; i++) begin
			idle_ticks(burst_at == i + 2, max_burst);
			if (cut == i + 1)
				return;
			value = 8'($urandom);
			total = total + 12'(value);
			send_byte(value);
		end
		idle_ticks(burst_at == n + 2, max_burst);
		if (cut > 0)
			return;
		value = frame_checksum(total);
		if (kind >= 18 && kind < 28)
			value = value ^ 8'($urandom_range(255, 1));
		send_byte(value);
	endtask

	// let the block drain and finish any deadline division, then write the rate
	task automatic reprogram(input logic [BAUD_W-1:0] rate);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= rate;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [BAUD_W-1:0] rate;
		flow_t flow;
		int max_burst;
		int mark;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle block ignores bytes, ticks and the spare command
		send_byte(SYNC_BYTE);
		send_tick();
		send_item(CMD_SPARE, '1, '1, '1);
		// id 0 protects to 0x80, so data 0x7f sums to 255 and the checksum is 0x00
		send_start(6'd0, 4'd1);
		send_byte(8'hAA);
		send_byte(SYNC_BYTE);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h00);
		// oversized length, abandoned by a new start, then a wrong checksum
		send_start(6'h3F, 4'hF);
		send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_start(6'h2A, 4'd0);
		send_byte(SYNC_BYTE);
		send_byte(8'h01);
		send_byte(~frame_checksum({4'd0, protect_id(6'h2A)}));
		// header deadline at the reset rate runs out on the fifth tick
		send_start(6'h15, 4'd8);
		repeat (5) send_tick();

		// random frames over a range of rates and flow patterns
		for (int p = 0; p < PHASE_COUNT; p++) begin
			rate = (p < CORNER_COUNT) ? corner_rates[p] : 15'($urandom_range(20000, 1000));
			reprogram(rate);
			flow = flow_t'(p % 4);
			case (flow)
				FLOW_FREE: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				FLOW_SENDER_GAPS: begin
					send_idle_pct = 47;
					stall_pct = 0;
				end
				FLOW_RECEIVER_STALLS: begin
					send_idle_pct = 0;
					stall_pct = 47;
				end
				default: begin
					send_idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			max_burst = (rate < 1000) ? 270 : 100;
			mark = sent_items;
			while (sent_items - mark < PHASE_ITEMS)
				send_frame(max_burst);
		end

		// drain and give the verdict
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_lin_frame_response_receiver: clean");
		else
			$display("tb_lin_frame_response_receiver: errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lfrr_pkg.sv
rtl/core/lfrr_ctrl.sv
rtl/core/lfrr_dpath.sv
rtl/core/lin_frame_response_receiver.sv
tb/lin_response_checker.sv
tb/tb_lin_frame_response_receiver.sv
